/* rtl/core/msbm_pkg.sv */
// shared types and codes of the multi-signature byte matcher
`default_nettype none

package msbm_pkg;

    // item kinds carried on s_tuser
    localparam logic [1:0] MODE_PAT_BYTE  = 2'd0;
    localparam logic [1:0] MODE_PAT_LEN   = 2'd1;
    localparam logic [1:0] MODE_FILE_BYTE = 2'd2;

    localparam int MODE_W   = 2;
    localparam int CFG_W    = 5;
    localparam int IN_DW    = 24;
    localparam int OUT_DW   = 40;
    localparam int SLOT_W   = 4;
    localparam int POS_W    = 5;
    localparam int PLEN_W   = 6;
    localparam int REPORT_W = 32;

    typedef struct packed {
        logic accept;   // input item taken this cycle
        logic ld_rd;    // read table row for a load
        logic ld_wr;    // write merged table row
        logic scan_rd;  // read next slot row for compare
        logic off_rd;   // read first offset of the winning slot
        logic report;   // load result register, clear file state
    } msbm_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] in_mode;
        logic              in_last;
        logic              in_use_zero;
        logic              scan_last;
        logic              out_free;
    } msbm_sts_t;

endpackage

`default_nettype wire

/* rtl/core/msbm_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none

module msbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/msbm_ctrl.sv */
// sequencer for loads, per-byte slot scan and end-of-file report
`default_nettype none

module msbm_ctrl
    import msbm_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire msbm_sts_t sts,
    output msbm_cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LD_RD,
        ST_LD_WR,
        ST_SCAN,
        ST_DRAIN,
        ST_OFF_RD,
        ST_REPORT
    } state_t;

    state_t state_reg, state_next;
    logic   rpt_reg, rpt_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        rpt_next   = rpt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (sts.in_mode)
                        MODE_PAT_BYTE, MODE_PAT_LEN: state_next = ST_LD_RD;
                        MODE_FILE_BYTE: begin
                            rpt_next = sts.in_last;
                            if (!sts.in_use_zero) begin
                                state_next = ST_SCAN;
                            end else if (sts.in_last) begin
                                state_next = ST_OFF_RD;
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LD_RD:  state_next = ST_LD_WR;
            ST_LD_WR:  state_next = ST_IDLE;
            ST_SCAN: begin
                if (sts.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = rpt_reg ? ST_OFF_RD : ST_IDLE;
            ST_OFF_RD: state_next = ST_REPORT;
            ST_REPORT: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd         = '0;
        cmd.accept  = accept;
        cmd.ld_rd   = (state_reg == ST_LD_RD);
        cmd.ld_wr   = (state_reg == ST_LD_WR);
        cmd.scan_rd = (state_reg == ST_SCAN);
        cmd.off_rd  = (state_reg == ST_OFF_RD);
        cmd.report  = (state_reg == ST_REPORT) && sts.out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rpt_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            rpt_reg   <= rpt_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/msbm_dp.sv */
// datapath: signature table, byte window, slot compare, hit tracking, result register
`default_nettype none

module msbm_dp
    import msbm_pkg::*;
#(
    parameter int MAX_SIGNATURES    = 16,
    parameter int MAX_PATTERN_BYTES = 32,
    parameter int OFFSET_BITS       = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire msbm_cmd_t         cmd,
    output msbm_sts_t              sts,
    input  wire logic [IN_DW-1:0]  s_tdata,
    input  wire logic [MODE_W-1:0] s_tuser,
    input  wire logic              s_tlast,
    input  wire logic              cfg_valid,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire logic              m_tready,
    output logic                   m_tvalid,
    output logic      [OUT_DW-1:0] m_tdata
);

    localparam int S     = MAX_SIGNATURES;
    localparam int P     = MAX_PATTERN_BYTES;
    localparam int OW    = OFFSET_BITS;
    localparam int AW    = (S > 1) ? $clog2(S) : 1;
    localparam int SW    = $clog2(S + 1);
    localparam int LW    = $clog2(P + 1);
    localparam int ROW_W = P * 8 + LW;
    localparam int CW    = (OW > LW) ? OW : LW;
    localparam int XW    = (OW > REPORT_W) ? OW : REPORT_W;

    // input fields
    logic [7:0]        in_data;
    logic [SLOT_W-1:0] in_slot;
    logic [POS_W-1:0]  in_pos;
    logic [PLEN_W-1:0] in_plen;

    assign in_data = s_tdata[7:0];
    assign in_slot = s_tdata[11:8];
    assign in_pos  = s_tdata[16:12];
    assign in_plen = s_tdata[22:17];

    // latched load item
    logic [MODE_W-1:0] item_mode_reg;
    logic [7:0]        item_data_reg;
    logic [SLOT_W-1:0] item_slot_reg;
    logic [POS_W-1:0]  item_pos_reg;
    logic [PLEN_W-1:0] item_plen_reg;

    logic [CFG_W-1:0]  cfg_reg;
    logic [SW-1:0]     in_use;
    logic [7:0]        window_reg [P];
    logic [OW-1:0]     count_reg;
    logic [S-1:0]      hit_reg;
    logic [SW-1:0]     scan_idx_reg;
    logic              cmp_valid_reg;
    logic [AW-1:0]     cmp_slot_reg;
    logic              found_reg;
    logic [AW-1:0]     best_reg;
    logic              m_valid_reg;
    logic [OUT_DW-1:0] m_data_reg;

    // table ram signals
    logic              pat_wr_en;
    logic [AW-1:0]     pat_wr_addr;
    logic [ROW_W-1:0]  pat_wr_data;
    logic              pat_rd_en;
    logic [AW-1:0]     pat_rd_addr;
    logic [ROW_W-1:0]  pat_rd_data;

    logic              off_wr_en;
    logic [OW-1:0]     off_wr_data;
    logic [OW-1:0]     off_rd_data;

    // compare stage
    logic [LW-1:0]     cmp_len;
    logic [LW-1:0]     shift_bytes;
    logic [P*8-1:0]    rev_vec;
    logic [P*8-1:0]    aligned;
    logic              bytes_eq;
    logic              new_hit;
    logic              slot_hit;

    logic              item_ok;
    logic [LW-1:0]     clamped_len;
    logic [XW-1:0]     off_ext;
    logic [REPORT_W-1:0] off_report;

    always_comb begin
        if (int'(cfg_reg) > S) begin
            in_use = SW'(S);
        end else begin
            in_use = SW'(cfg_reg);
        end
    end

    assign sts.in_mode     = s_tuser;
    assign sts.in_last     = s_tlast;
    assign sts.in_use_zero = (in_use == '0);
    assign sts.scan_last   = ((scan_idx_reg + SW'(1)) == in_use);
    assign sts.out_free    = !m_valid_reg || m_tready;

    // load path: read-modify-write of one table row
    always_comb begin
        item_ok = (int'(item_slot_reg) < S) &&
                  ((item_mode_reg == MODE_PAT_LEN) || (int'(item_pos_reg) < P));
        if (int'(item_plen_reg) > P) begin
            clamped_len = LW'(P);
        end else begin
            clamped_len = LW'(item_plen_reg);
        end
        pat_wr_data = pat_rd_data;
        if (item_mode_reg == MODE_PAT_LEN) begin
            pat_wr_data[P*8 +: LW] = clamped_len;
        end else begin
            for (int k = 0; k < P; k++) begin
                if (int'(item_pos_reg) == k) begin
                    pat_wr_data[k*8 +: 8] = item_data_reg;
                end
            end
        end
    end

    assign pat_wr_en   = cmd.ld_wr && item_ok;
    assign pat_wr_addr = AW'(item_slot_reg);
    assign pat_rd_en   = cmd.ld_rd || cmd.scan_rd;
    assign pat_rd_addr = cmd.ld_rd ? AW'(item_slot_reg) : scan_idx_reg[AW-1:0];

    msbm_ram #(
        .WIDTH (ROW_W),
        .DEPTH (S)
    ) u_pat_ram (
        .aclk    (aclk),
        .wr_en   (pat_wr_en),
        .wr_addr (pat_wr_addr),
        .wr_data (pat_wr_data),
        .rd_en   (pat_rd_en),
        .rd_addr (pat_rd_addr),
        .rd_data (pat_rd_data)
    );

    // align the window so that byte k faces pattern byte k for this length
    always_comb begin
        cmp_len     = pat_rd_data[P*8 +: LW];
        shift_bytes = LW'(P) - cmp_len;
        for (int j = 0; j < P; j++) begin
            rev_vec[j*8 +: 8] = window_reg[P-1-j];
        end
        aligned  = rev_vec >> {shift_bytes, 3'b000};
        bytes_eq = 1'b1;
        for (int k = 0; k < P; k++) begin
            if ((LW'(k) < cmp_len) && (aligned[k*8 +: 8] != pat_rd_data[k*8 +: 8])) begin
                bytes_eq = 1'b0;
            end
        end
        new_hit = cmp_valid_reg && !hit_reg[cmp_slot_reg] &&
                  ((cmp_len == '0) ||
                   ((CW'(count_reg) >= CW'(cmp_len)) && bytes_eq));
        slot_hit = cmp_valid_reg && (hit_reg[cmp_slot_reg] || new_hit);
        if (cmp_len == '0) begin
            off_wr_data = '0;
        end else begin
            off_wr_data = count_reg - OW'(cmp_len);
        end
    end

    assign off_wr_en = new_hit;

    msbm_ram #(
        .WIDTH (OW),
        .DEPTH (S)
    ) u_off_ram (
        .aclk    (aclk),
        .wr_en   (off_wr_en),
        .wr_addr (cmp_slot_reg),
        .wr_data (off_wr_data),
        .rd_en   (cmd.off_rd),
        .rd_addr (best_reg),
        .rd_data (off_rd_data)
    );

    always_comb begin
        off_ext = XW'(off_rd_data);
        if (off_ext > XW'({REPORT_W{1'b1}})) begin
            off_report = '1;
        end else begin
            off_report = off_ext[REPORT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg       <= '0;
            count_reg     <= '0;
            hit_reg       <= '0;
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < P; i++) begin
                window_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                cfg_reg <= cfg_data;
            end

            cmp_valid_reg <= cmd.scan_rd;

            if (cmd.accept && (s_tuser == MODE_FILE_BYTE)) begin
                for (int i = P - 1; i > 0; i--) begin
                    window_reg[i] <= window_reg[i-1];
                end
                window_reg[0] <= in_data;
                if (count_reg != '1) begin
                    count_reg <= count_reg + OW'(1);
                end
                scan_idx_reg <= '0;
                found_reg    <= 1'b0;
            end

            if (cmd.scan_rd) begin
                scan_idx_reg <= scan_idx_reg + SW'(1);
            end

            if (new_hit) begin
                hit_reg[cmp_slot_reg] <= 1'b1;
            end
            // slots are visited in order, so the first hit seen is the lowest
            if (slot_hit && !found_reg) begin
                found_reg <= 1'b1;
            end

            if (cmd.report) begin
                m_valid_reg <= 1'b1;
                hit_reg     <= '0;
                count_reg   <= '0;
                for (int i = 0; i < P; i++) begin
                    window_reg[i] <= '0;
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_mode_reg <= s_tuser;
            item_data_reg <= in_data;
            item_slot_reg <= in_slot;
            item_pos_reg  <= in_pos;
            item_plen_reg <= in_plen;
        end
        if (cmd.scan_rd) begin
            cmp_slot_reg <= scan_idx_reg[AW-1:0];
        end
        if (slot_hit && !found_reg) begin
            best_reg <= cmp_slot_reg;
        end
        if (cmd.report) begin
            if (found_reg) begin
                m_data_reg <= {3'b000, off_report, SLOT_W'(best_reg), 1'b1};
            end else begin
                m_data_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

/* rtl/core/multi_signature_byte_matcher_top.sv */
// top level of the multi-signature byte matcher
//
//  channel   dir  handshake              payload
//  s_        in   s_tvalid / s_tready    s_tdata, s_tuser = mode, s_tlast = last_byte
//  m_        out  m_tvalid / m_tready    m_tdata: one result per last file byte
//  cfg_      in   cfg_valid / cfg_ready  cfg_data = signatures_in_use
//
// a signature byte or length item goes through table row read, merge and write back
// a file byte scans the n = slots in use table rows in order, and skips the scan when n = 0;
// one slot row per cycle from the table ram is compared against the whole window at once
// a last file byte adds the offset read and the result load
// reset clears the window, byte count and hit flags; table contents stay undefined
// one result register: a further last byte waits until the pending result is taken
`default_nettype none

module multi_signature_byte_matcher_top
    import msbm_pkg::*;
#(
    parameter int MAX_SIGNATURES    = 16,
    parameter int MAX_PATTERN_BYTES = 32,
    parameter int OFFSET_BITS       = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // data_byte[7:0], slot[11:8], byte_position[16:12], pattern_length[22:17], zero[23]
    input  wire logic [IN_DW-1:0]  s_tdata,
    // mode[1:0]
    input  wire logic [MODE_W-1:0] s_tuser,
    input  wire logic              s_tlast,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // match_found[0], matched_slot[4:1], match_offset[36:5], zero[39:37]
    output logic      [OUT_DW-1:0] m_tdata,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CFG_W-1:0]  cfg_data
);

    msbm_cmd_t cmd;
    msbm_sts_t sts;

    assign cfg_ready = 1'b1;

    msbm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    msbm_dp #(
        .MAX_SIGNATURES    (MAX_SIGNATURES),
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
        .OFFSET_BITS       (OFFSET_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

/* tb/tb.sv */
// testbench for the multi-signature byte matcher: queued stimulus, scan predictor, result checker
`timescale 1ns / 1ps

module tb;
    import msbm_pkg::*;

    localparam logic [1:0] MODE_IGNORED = 2'd3;
    localparam int NUM_SLOTS   = 16;
    localparam int SIG_BYTES   = 32;
    localparam int SETTLE_CYC  = 40;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [1:0]        mode;
        logic [7:0]        data;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  pos;
        logic [PLEN_W-1:0] plen;
        logic              last;
    } scan_item_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       offset;
    } scan_report_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [IN_DW-1:0]     s_tdata   = '0;
    logic [MODE_W-1:0]    s_tuser   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [OUT_DW-1:0]    m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data  = '0;

    multi_signature_byte_matcher_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [7:0]        sig_bytes [NUM_SLOTS][SIG_BYTES];
    logic [PLEN_W-1:0] sig_len [NUM_SLOTS];
    logic [7:0]        recent_win [SIG_BYTES];
    logic [31:0]       file_count;
    logic              slot_hit [NUM_SLOTS];
    logic [31:0]       slot_first_off [NUM_SLOTS];
    logic [CFG_W-1:0]  slots_in_use = '0;

    // generator view of the table, so no unwritten entry is ever read
    logic [7:0]        gen_pat [NUM_SLOTS][SIG_BYTES];
    bit                gen_written [NUM_SLOTS][SIG_BYTES];
    int                gen_len [NUM_SLOTS];

    scan_item_t   pending_q [$];
    scan_report_t report_q [$];
    scan_item_t   cur_item;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int phase_items   = 0;
    int err_count     = 0;
    int n_items       = 0;
    int n_reports     = 0;
    int n_hits        = 0;
    int cycle_count   = 0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: cycle limit reached with %0d reports pending", report_q.size());
            $display("tb: done, errors");
            $finish;
        end
    end

    function automatic logic window_hit(int s, int len);
        for (int k = 0; k < len; k++) begin
            if (sig_bytes[s][k] != recent_win[len - 1 - k])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic clear_file();
        for (int i = 0; i < SIG_BYTES; i++)
            recent_win[i] = 8'h00;
        for (int s = 0; s < NUM_SLOTS; s++)
            slot_hit[s] = 1'b0;
        file_count = '0;
    endtask

    task automatic scan_model_step(input scan_item_t it);
        int active;
        int len;
        scan_report_t rep;
        active = (slots_in_use > NUM_SLOTS) ? NUM_SLOTS : int'(slots_in_use);
        case (it.mode)
            MODE_PAT_BYTE: begin
                sig_bytes[it.slot][it.pos] = it.data;
            end
            MODE_PAT_LEN: begin
                sig_len[it.slot] = (it.plen > SIG_BYTES) ? PLEN_W'(SIG_BYTES) : it.plen;
            end
            MODE_FILE_BYTE: begin
                for (int i = SIG_BYTES - 1; i > 0; i--)
                    recent_win[i] = recent_win[i - 1];
                recent_win[0] = it.data;
                if (file_count != 32'hFFFF_FFFF)
                    file_count = file_count + 1;
                for (int s = 0; s < active; s++) begin
                    len = sig_len[s];
                    if (!slot_hit[s]) begin
                        if (len == 0) begin
                            slot_hit[s] = 1'b1;
                            slot_first_off[s] = '0;
                        end else if (file_count >= len && window_hit(s, len)) begin
                            slot_hit[s] = 1'b1;
                            slot_first_off[s] = file_count - len;
                        end
                    end
                end
                if (it.last) begin
                    rep = '0;
                    for (int s = active - 1; s >= 0; s--) begin
                        if (slot_hit[s]) begin
                            rep.found  = 1'b1;
                            rep.slot   = SLOT_W'(s);
                            rep.offset = slot_first_off[s];
                        end
                    end
                    report_q.push_back(rep);
                    clear_file();
                end
            end
            default: ;
        endcase
    endtask

    // driver: takes the next queued item once the current one is accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                scan_model_step(cur_item);
                n_items++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cur_item = pending_q.pop_front();
                    s_tdata  <= {1'b0, cur_item.plen, cur_item.pos, cur_item.slot,
                                 cur_item.data};
                    s_tuser  <= cur_item.mode;
                    s_tlast  <= cur_item.last;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic flag_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        err_count++;
        if (err_count <= 10)
            $display("tb: report %0d %s mismatch: expected %0h, got %0h",
                     n_reports, what, exp_v, act_v);
    endtask

    // monitor: every accepted result against the oldest prediction
    always @(posedge aclk) begin
        scan_report_t want;
        scan_report_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.found  = m_tdata[0];
            got.slot   = m_tdata[4:1];
            got.offset = m_tdata[36:5];
            if (report_q.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("tb: unexpected report: found %0b slot %0d offset %0d",
                             got.found, got.slot, got.offset);
            end else begin
                want = report_q.pop_front();
                if (got.found != want.found)
                    flag_mismatch("match_found", want.found, got.found);
                if (got.slot != want.slot)
                    flag_mismatch("matched_slot", want.slot, got.slot);
                if (got.offset != want.offset)
                    flag_mismatch("match_offset", want.offset, got.offset);
                if (want.found)
                    n_hits++;
            end
            n_reports++;
        end
    end

    function automatic logic [7:0] pick_byte();
        logic [7:0] pool [4] = '{8'h00, 8'hFF, 8'hA5, 8'h3C};
        if ($urandom_range(0, 1) == 0)
            return pool[$urandom_range(0, 3)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic add_item(input logic [1:0] mode, input logic [7:0] data,
                            input logic [SLOT_W-1:0] slot, input logic [POS_W-1:0] pos,
                            input logic [PLEN_W-1:0] plen, input logic last);
        scan_item_t it;
        it = '{mode: mode, data: data, slot: slot, pos: pos, plen: plen, last: last};
        pending_q.push_back(it);
        if (mode != MODE_IGNORED)
            phase_items++;
    endtask

    task automatic add_pat_byte(input int s, input int p, input logic [7:0] d);
        gen_pat[s][p] = d;
        gen_written[s][p] = 1'b1;
        add_item(MODE_PAT_BYTE, d, SLOT_W'(s), POS_W'(p), PLEN_W'($urandom_range(0, 63)),
                 1'($urandom_range(0, 1)));
    endtask

    task automatic add_pat_len(input int s, input int pl);
        gen_len[s] = (pl > SIG_BYTES) ? SIG_BYTES : pl;
        add_item(MODE_PAT_LEN, 8'($urandom_range(0, 255)), SLOT_W'(s),
                 POS_W'($urandom_range(0, 31)), PLEN_W'(pl), 1'($urandom_range(0, 1)));
    endtask

    task automatic add_file_byte(input logic [7:0] d, input logic last);
        add_item(MODE_FILE_BYTE, d, SLOT_W'($urandom_range(0, 15)),
                 POS_W'($urandom_range(0, 31)), PLEN_W'($urandom_range(0, 63)), last);
    endtask

    task automatic add_junk();
        add_item(MODE_IGNORED, 8'($urandom_range(0, 255)), SLOT_W'($urandom_range(0, 15)),
                 POS_W'($urandom_range(0, 31)), PLEN_W'($urandom_range(0, 63)),
                 1'($urandom_range(0, 1)));
    endtask

    task automatic program_slot(input int s, input int len);
        int pl;
        for (int k = 0; k < len; k++)
            add_pat_byte(s, k, pick_byte());
        // a full-length signature is sometimes given an overlong length
        pl = (len == SIG_BYTES && $urandom_range(0, 1)) ? $urandom_range(33, 63) : len;
        add_pat_len(s, pl);
    endtask

    // stray item: ignored mode, a table byte, or a length covered by written bytes
    task automatic add_noise();
        int r;
        int s;
        int prefix;
        r = $urandom_range(0, 2);
        s = $urandom_range(0, NUM_SLOTS - 1);
        if (r == 0) begin
            add_junk();
        end else if (r == 1) begin
            add_pat_byte(s, $urandom_range(0, SIG_BYTES - 1), pick_byte());
        end else begin
            prefix = 0;
            while (prefix < SIG_BYTES && gen_written[s][prefix])
                prefix++;
            add_pat_len(s, (prefix == SIG_BYTES) ? $urandom_range(0, 63)
                                                 : $urandom_range(0, prefix));
        end
    endtask

    task automatic gen_file(input int flen);
        logic [7:0] fbytes [];
        int s;
        int p;
        fbytes = new[flen];
        for (int i = 0; i < flen; i++)
            fbytes[i] = pick_byte();
        // usually plant one signature somewhere in the file
        if ($urandom_range(0, 99) < 70) begin
            for (int t = 0; t < 8; t++) begin
                s = $urandom_range(0, NUM_SLOTS - 1);
                if (gen_len[s] > 0 && gen_len[s] <= flen) begin
                    p = $urandom_range(0, flen - gen_len[s]);
                    for (int k = 0; k < gen_len[s]; k++)
                        fbytes[p + k] = gen_pat[s][k];
                    break;
                end
            end
        end
        for (int i = 0; i < flen; i++) begin
            add_file_byte(fbytes[i], i == flen - 1);
            if (i < flen - 1 && $urandom_range(0, 99) < 4)
                add_noise();
        end
    endtask

    function automatic int pick_sig_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 0;
        if (r < 70)
            return $urandom_range(1, 4);
        if (r < 85)
            return $urandom_range(5, 31);
        return SIG_BYTES;
    endfunction

    task automatic run_phase(input int target);
        int r;
        phase_items = 0;
        while (phase_items < target) begin
            r = $urandom_range(0, 99);
            if (r < 65)
                gen_file(($urandom_range(0, 99) < 85) ? $urandom_range(1, 12)
                                                     : $urandom_range(30, 45));
            else if (r < 80)
                program_slot($urandom_range(0, NUM_SLOTS - 1), pick_sig_len());
            else
                add_noise();
        end
    endtask

    // wait until every item is taken and every report is back, then let the block settle
    task automatic drain();
        do
            @(negedge aclk);
        while (pending_q.size() != 0 || s_tvalid || report_q.size() != 0);
        repeat (SETTLE_CYC) @(negedge aclk);
    endtask

    task automatic write_in_use(input logic [CFG_W-1:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        slots_in_use = v;
        @(negedge aclk);
    endtask

    initial begin
        clear_file();
        for (int s = 0; s < NUM_SLOTS; s++) begin
            gen_len[s] = 0;
            for (int k = 0; k < SIG_BYTES; k++)
                gen_written[s][k] = 1'b0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: data extremes, zero length, far byte position, ignored mode
        send_idle_pct = 10;
        recv_idle_pct = 84;
        write_in_use(5'd4);
        add_pat_byte(0, 0, 8'hFF);
        add_pat_byte(0, 1, 8'h00);
        add_pat_len(0, 2);
        add_pat_byte(1, 0, 8'h5A);
        add_pat_len(1, 1);
        add_pat_len(2, 0);
        add_pat_byte(3, 0, 8'h11);
        add_pat_byte(3, 1, 8'h22);
        add_pat_byte(3, 2, 8'h33);
        add_pat_byte(3, SIG_BYTES - 1, 8'hAA);
        add_pat_len(3, 3);
        add_file_byte(8'hFF, 1'b0);
        add_file_byte(8'h00, 1'b1);
        add_file_byte(8'h5A, 1'b1);
        add_file_byte(8'h11, 1'b0);
        add_file_byte(8'h22, 1'b0);
        add_junk();
        add_file_byte(8'hFF, 1'b0);
        add_file_byte(8'h00, 1'b1);
        add_file_byte(8'h33, 1'b1);
        add_pat_byte(2, 0, 8'h7E);
        add_pat_len(2, 1);
        add_file_byte(8'h22, 1'b0);
        add_file_byte(8'h33, 1'b1);
        add_file_byte(8'h11, 1'b0);
        add_file_byte(8'h22, 1'b0);
        add_file_byte(8'h33, 1'b1);

        // fill the rest of the table before more slots are searched
        program_slot(4, SIG_BYTES);
        for (int s = 5; s < NUM_SLOTS; s++)
            program_slot(s, pick_sig_len());
        drain();

        write_in_use(5'd16);
        run_phase(100);
        drain();

        write_in_use(5'd0);
        run_phase(15);
        drain();

        send_idle_pct = 84;
        recv_idle_pct = 10;
        write_in_use(5'd31);
        run_phase(90);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_in_use(CFG_W'($urandom_range(1, 15)));
        run_phase(70);
        drain();

        write_in_use(5'd1);
        run_phase(25);
        drain();

        if (report_q.size() != 0)
            err_count += report_q.size();
        $display("tb: %0d items taken, %0d reports checked, %0d of them with a hit",
                 n_items, n_reports, n_hits);
        $display("tb: slot counts 0, 1, 4, 16, 31 and one random; lengths zero to overlong");
        if (err_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: %0d mismatches", err_count);
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/msbm_pkg.sv
rtl/core/msbm_ram.sv
rtl/core/msbm_ctrl.sv
rtl/core/msbm_dp.sv
rtl/core/multi_signature_byte_matcher_top.sv
tb/tb.sv
